[src/crcfr_pkg.sv]
// Shared constants, codes and the bytewise CRC-16/X25 update for the frame receiver.
package crcfr_pkg;

	localparam int CNT_W = 32;

	localparam logic [7:0] HDR_FIRST = 8'hFF;
	localparam logic [7:0] HDR_SECOND = 8'hBB;
	localparam logic [7:0] MIN_FRAME_LEN = 8'd6;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8408;

	localparam logic [1:0] PH_HUNT1 = 2'd0;
	localparam logic [1:0] PH_HUNT2 = 2'd1;
	localparam logic [1:0] PH_LEN = 2'd2;
	localparam logic [1:0] PH_BODY = 2'd3;

	localparam logic [1:0] ST_GOOD = 2'd0;
	localparam logic [1:0] ST_CRC_BAD = 2'd1;
	localparam logic [1:0] ST_BAD_LEN = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	localparam logic [1:0] REG_MAX_LEN = 2'd0;
	localparam logic [1:0] REG_GPS_ID = 2'd1;
	localparam logic [1:0] REG_DEVICE_ID = 2'd2;

	function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[src/crc_checked_frame_receiver.sv]
// Top level of the length-prefixed frame receiver with CRC-16/X25 check.
// An accepted request is registered in the input register, and its result in the result register.
// Throughput: one request per cycle while the result is not held; the bytewise CRC update is combinational.
// The input register and the result register only stall when the result is held.
// Reset clears the parser to the header hunt, the counters to zero and the
// registers to a length limit of 255, position id 1 and device id 2.
module crc_checked_frame_receiver
	import crcfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	input  logic        idle_tick,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  payload_byte,
	output logic        end_of_frame,
	output logic [1:0]  status,
	output logic [7:0]  frame_id,
	output logic [7:0]  frame_length,
	output logic [31:0] gps_frames,
	output logic [31:0] device_frames
);

	logic [7:0] max_len_q;
	logic [7:0] gps_id_q;
	logic [7:0] device_id_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       tick_s1;

	logic [1:0]       phase_q;
	logic [7:0]       pos_q;
	logic [7:0]       exp_len_q;
	logic [15:0]      crc_q;
	logic [7:0]       crc_low_q;
	logic [7:0]       held_id_q;
	logic [CNT_W-1:0] gps_q;
	logic [CNT_W-1:0] dev_q;

	logic        res_valid_q;
	logic [7:0]  payload_q;
	logic        eof_q;
	logic [1:0]  status_q;
	logic [7:0]  id_q;
	logic [7:0]  len_q;
	logic [31:0] gps_out_q;
	logic [31:0] dev_out_q;

	logic             advance;
	logic             cfg_wr;
	logic [1:0]       phase_d;
	logic [7:0]       pos_d;
	logic [7:0]       exp_len_d;
	logic [15:0]      crc_d;
	logic [7:0]       crc_low_d;
	logic [7:0]       held_id_d;
	logic [CNT_W-1:0] gps_d;
	logic [CNT_W-1:0] dev_d;
	logic             emit;
	logic [7:0]       o_payload;
	logic             o_eof;
	logic [1:0]       o_status;
	logic [7:0]       o_id;
	logic [7:0]       o_len;
	logic [15:0]      crc_feed_val;
	logic [8:0]       pos_plus2;
	logic [15:0]      crc_got;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 8'd255;
			gps_id_q <= 8'd1;
			device_id_q <= 8'd2;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MAX_LEN: max_len_q <= pwdata[7:0];
				REG_GPS_ID: gps_id_q <= pwdata[7:0];
				REG_DEVICE_ID: device_id_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MAX_LEN: prdata = {24'h0, max_len_q};
			REG_GPS_ID: prdata = {24'h0, gps_id_q};
			REG_DEVICE_ID: prdata = {24'h0, device_id_q};
			default: prdata = 32'h0;
		endcase
	end

	assign advance = valid_s1 && (!res_valid_q || !res_stall);
	assign rx_stall = valid_s1 && !(!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			byte_s1 <= rx_byte;
			tick_s1 <= idle_tick;
		end
	end

	assign crc_feed_val = crc_feed(crc_q, byte_s1);
	assign pos_plus2 = {1'b0, pos_q} + 9'd2;
	assign crc_got = {byte_s1, crc_low_q};

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		exp_len_d = exp_len_q;
		crc_d = crc_q;
		crc_low_d = crc_low_q;
		held_id_d = held_id_q;
		gps_d = gps_q;
		dev_d = dev_q;
		emit = 1'b0;
		o_payload = 8'h00;
		o_eof = 1'b0;
		o_status = ST_GOOD;
		o_id = 8'h00;
		o_len = 8'h00;
		if (tick_s1) begin
			if (phase_q == PH_BODY) begin
				emit = 1'b1;
				o_eof = 1'b1;
				o_status = ST_TIMEOUT;
				o_id = held_id_q;
				o_len = exp_len_q;
			end
			phase_d = PH_HUNT1;
			pos_d = 8'd0;
			crc_d = CRC_INIT;
		end else begin
			case (phase_q)
				PH_HUNT1: begin
					if (byte_s1 == HDR_FIRST) begin
						crc_d = crc_feed(CRC_INIT, byte_s1);
						pos_d = 8'd1;
						phase_d = PH_HUNT2;
					end
				end
				PH_HUNT2: begin
					if (byte_s1 == HDR_SECOND) begin
						crc_d = crc_feed_val;
						pos_d = 8'd2;
						phase_d = PH_LEN;
					end else begin
						phase_d = PH_HUNT1;
						pos_d = 8'd0;
						crc_d = CRC_INIT;
					end
				end
				PH_LEN: begin
					exp_len_d = byte_s1;
					held_id_d = 8'h00;
					if (byte_s1 < MIN_FRAME_LEN || byte_s1 > max_len_q) begin
						emit = 1'b1;
						o_eof = 1'b1;
						o_status = ST_BAD_LEN;
						o_len = byte_s1;
						phase_d = PH_HUNT1;
						pos_d = 8'd0;
						crc_d = CRC_INIT;
					end else begin
						crc_d = crc_feed_val;
						pos_d = 8'd3;
						phase_d = PH_BODY;
					end
				end
				default: begin
					if (pos_q == 8'd3) begin
						held_id_d = byte_s1;
						crc_d = crc_feed_val;
						pos_d = 8'd4;
					end else if (pos_plus2 < {1'b0, exp_len_q}) begin
						crc_d = crc_feed_val;
						pos_d = pos_q + 8'd1;
						emit = 1'b1;
						o_payload = byte_s1;
					end else if (pos_plus2 == {1'b0, exp_len_q}) begin
						crc_low_d = byte_s1;
						pos_d = pos_q + 8'd1;
					end else begin
						emit = 1'b1;
						o_eof = 1'b1;
						o_id = held_id_q;
						o_len = exp_len_q;
						if (crc_got == ~crc_q) begin
							o_status = ST_GOOD;
							if (held_id_q == gps_id_q) begin
								gps_d = gps_q + CNT_W'(1);
							end else if (held_id_q == device_id_q) begin
								dev_d = dev_q + CNT_W'(1);
							end
						end else begin
							o_status = ST_CRC_BAD;
						end
						phase_d = PH_HUNT1;
						pos_d = 8'd0;
						crc_d = CRC_INIT;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			pos_q <= 8'd0;
			exp_len_q <= 8'd0;
			crc_q <= CRC_INIT;
			crc_low_q <= 8'd0;
			held_id_q <= 8'd0;
			gps_q <= '0;
			dev_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			exp_len_q <= exp_len_d;
			crc_q <= crc_d;
			crc_low_q <= crc_low_d;
			held_id_q <= held_id_d;
			gps_q <= gps_d;
			dev_q <= dev_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			payload_q <= o_payload;
			eof_q <= o_eof;
			status_q <= o_status;
			id_q <= o_id;
			len_q <= o_len;
			gps_out_q <= o_eof ? 32'(gps_d) : 32'h0;
			dev_out_q <= o_eof ? 32'(dev_d) : 32'h0;
		end
	end

	assign res_valid = res_valid_q;
	assign payload_byte = payload_q;
	assign end_of_frame = eof_q;
	assign status = status_q;
	assign frame_id = id_q;
	assign frame_length = len_q;
	assign gps_frames = gps_out_q;
	assign device_frames = dev_out_q;

`ifndef SYNTHESIS
	a_phase_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BODY) == (pos_q >= 8'd3))
		else $error("Byte position does not agree with the parse phase.");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !end_of_frame) |-> (status == ST_GOOD && frame_id == 8'h00
			&& frame_length == 8'h00 && gps_frames == 32'h0 && device_frames == 32'h0))
		else $error("Payload result carries verdict fields.");

	a_gps_step: assert property (@(posedge clk) disable iff (!arst_n)
		(gps_q != $past(gps_q)) |-> (gps_q == $past(gps_q) + CNT_W'(1)))
		else $error("Position frame counter moved by more than one.");

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		rx_stall |-> (valid_s1 && res_valid_q))
		else $error("Input stalled while the result register was free.");
`endif

endmodule
